// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is asserted
`define SLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SLCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/slcd_pkg.sv =====
`default_nettype none

package slcd_pkg;

    localparam int unsigned BYTE_W = 8;

    // Reset values of the start-of-frame bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h4B;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hB4;

    // Configuration register indexes
    typedef enum logic {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } cfg_reg_t;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_SYNC1 = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_BODY  = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/sync_length_checksum_deframer.sv =====
// Frame parser for a serial byte stream.
// Input channel: one received byte per transaction on rx_byte (in_valid/in_ready).
// The block hunts for two start bytes (sync_first, sync_second), then takes a
// length byte L and passes the next L bytes out as the frame body.
// Output channel (out_valid/out_ready): one transaction per body byte with
// frame_byte, is_first, is_last, body_length, and sum_ok on the last byte
// (length plus all body bytes sum to zero modulo 256). Start and length bytes
// produce no output; a zero length drops the frame.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_addr
// (0 = sync_first, 1 = sync_second); write only while idle.
// Latency: a body byte appears on the output the cycle after it is accepted.
// Throughput: one byte per cycle; the single output register is refilled in
// the same cycle it is drained, so in_ready = !out_valid || out_ready.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken.
// Reset (rst_n low, asynchronous): registers go to 0x4B / 0xB4, the parser
// returns to hunting, the output register empties.
`default_nettype none

module sync_length_checksum_deframer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [slcd_pkg::BYTE_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [slcd_pkg::BYTE_W-1:0] rx_byte,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [slcd_pkg::BYTE_W-1:0]      frame_byte,
    output logic                             is_first,
    output logic                             is_last,
    output logic                             sum_ok,
    output logic [slcd_pkg::BYTE_W-1:0]      body_length
);
    import slcd_pkg::*;

    `include "assert_macros.svh"

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] frame_len_reg, frame_len_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] frame_byte_reg;
    logic              is_first_reg;
    logic              is_last_reg;
    logic              sum_ok_reg;
    logic [BYTE_W-1:0] body_length_reg;

    logic              in_accept;
    logic              emit;
    logic              body_first;
    logic              body_last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Body byte marks
    assign body_first       = (bytes_left_reg == frame_len_reg);
    assign bytes_left_next  = (phase_reg == PH_BODY) ? bytes_left_reg - 8'd1 : rx_byte;
    assign body_last        = (bytes_left_reg == 8'd1);
    assign running_sum_next = (phase_reg == PH_BODY) ? running_sum_reg + rx_byte : rx_byte;

    // Next phase and frame length
    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        emit           = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == sync_first_reg)
                    phase_next = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                if (rx_byte == sync_second_reg)
                    phase_next = PH_LEN;
                else if (rx_byte == sync_first_reg)
                    phase_next = PH_SYNC1;
                else
                    phase_next = PH_HUNT;
            end
            PH_LEN:
            begin
                if (rx_byte == 8'd0)
                    phase_next = PH_HUNT;
                else
                begin
                    phase_next     = PH_BODY;
                    frame_len_next = rx_byte;
                end
            end
            PH_BODY:
            begin
                emit = 1'b1;
                if (body_last)
                    phase_next = PH_HUNT;
            end
            default:
                phase_next = PH_HUNT;
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            frame_len_reg   <= '0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_LEN || phase_reg == PH_BODY)
            begin
                frame_len_reg   <= frame_len_next;
                bytes_left_reg  <= bytes_left_next;
                running_sum_reg <= running_sum_next;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_accept && emit;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            frame_byte_reg  <= rx_byte;
            is_first_reg    <= body_first;
            is_last_reg     <= body_last;
            sum_ok_reg      <= body_last && (running_sum_next == 8'd0);
            body_length_reg <= frame_len_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign is_first    = is_first_reg;
    assign is_last     = is_last_reg;
    assign sum_ok      = sum_ok_reg;
    assign body_length = body_length_reg;

    // Checks
    `SLCD_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_valid_reg,
        "output register not empty during reset")
    `SLCD_ASSERT(a_body_count_nonzero, (phase_reg == PH_BODY) |-> (bytes_left_reg != 8'd0),
        "in body with no bytes left")
    `SLCD_ASSERT(a_body_count_bounded,
        (phase_reg == PH_BODY) |-> (bytes_left_reg <= frame_len_reg),
        "bytes left exceeds frame length")
    `SLCD_ASSERT(a_last_returns_to_hunt,
        (in_accept && phase_reg == PH_BODY && body_last) |=> (phase_reg == PH_HUNT),
        "last body byte did not return to hunting")
    `SLCD_ASSERT(a_zero_length_drops,
        (in_accept && phase_reg == PH_LEN && rx_byte == 8'd0) |=> (phase_reg == PH_HUNT),
        "zero length did not drop the frame")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // one body byte as the parser should emit it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              ok;
        logic [BYTE_W-1:0] length;
    } body_byte_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_QUARTER,
        RDY_BURSTY
    } ready_mode_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_reg_t          cfg_addr;
    logic [BYTE_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              is_first;
    logic              is_last;
    logic              sum_ok;
    logic [BYTE_W-1:0] body_length;

    // stimulus and expectations
    logic [BYTE_W-1:0] rx_pending[$];
    body_byte_t        body_due[$];
    logic              in_busy;
    int unsigned       burst_left;
    int unsigned       gap_left;
    ready_mode_t       ready_mode;
    int unsigned       ready_hold;
    int unsigned       cycle_count;
    int unsigned       fail_count;

    // parser shadow state
    phase_t            parse_phase;
    logic [BYTE_W-1:0] cur_len;
    logic [BYTE_W-1:0] remaining;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;

    sync_length_checksum_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .is_first    (is_first),
        .is_last     (is_last),
        .sum_ok      (sum_ok),
        .body_length (body_length)
    );

    always #4 clk = ~clk;

    // advance the shadow parser by one accepted byte
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        body_byte_t res;
        case (parse_phase)
            PH_HUNT:
            begin
                if (b == sync_a)
                    parse_phase = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                if (b == sync_b)
                    parse_phase = PH_LEN;
                else if (b != sync_a)
                    parse_phase = PH_HUNT;
            end
            PH_LEN:
            begin
                // zero length drops the frame
                if (b == '0)
                    parse_phase = PH_HUNT;
                else
                begin
                    cur_len     = b;
                    remaining   = b;
                    csum        = b;
                    parse_phase = PH_BODY;
                end
            end
            default:
            begin
                csum       = csum + b;
                res.data   = b;
                res.first  = (remaining == cur_len);
                remaining  = remaining - 8'd1;
                res.last   = (remaining == '0);
                res.ok     = res.last && (csum == '0);
                res.length = cur_len;
                if (res.last)
                    parse_phase = PH_HUNT;
                body_due.push_back(res);
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s: got 0x%0h, want 0x%0h",
                 cycle_count, what, got, want);
        fail_count++;
    endtask

    // register write; shadow copy is set as the write is driven, ahead of the edge that loads the register
    task automatic write_sync(input cfg_reg_t idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == REG_SYNC_FIRST)
            sync_a = value;
        else
            sync_b = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold off until every queued byte is taken and every body byte has come out
    task automatic wait_idle();
        while (rx_pending.size() != 0 || in_busy || body_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // sync pair, length, body with checksum (correct or corrupted)
    task automatic queue_frame(input int unsigned len, input bit good);
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] v;
        rx_pending.push_back(sync_a);
        rx_pending.push_back(sync_b);
        rx_pending.push_back(len[BYTE_W-1:0]);
        s = len[BYTE_W-1:0];
        for (int i = 1; i < len; i++)
        begin
            v = 8'($urandom);
            s = s + v;
            rx_pending.push_back(v);
        end
        v = -s;
        if (!good)
            v = v + 8'($urandom_range(1, 255));
        rx_pending.push_back(v);
    endtask

    // mostly well-formed frames, the rest noise and broken headers
    task automatic queue_random(input int unsigned n);
        int unsigned pick;
        int unsigned len;
        int unsigned stop_at;
        stop_at = rx_pending.size() + n;
        while (rx_pending.size() < stop_at)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            if (pick < 70)
                queue_frame(len, $urandom_range(0, 9) < 7);
            else if (pick < 80)
                rx_pending.push_back(8'($urandom));
            else if (pick < 86)
            begin
                rx_pending.push_back(sync_a);
                rx_pending.push_back(sync_b);
                rx_pending.push_back('0);
            end
            else if (pick < 93)
            begin
                rx_pending.push_back(sync_a);
                queue_frame(len, 1'b1);
            end
            else
            begin
                rx_pending.push_back(sync_a);
                rx_pending.push_back(8'($urandom));
            end
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin : drive_rx
        int unsigned pick;
        if (rst_n && !in_busy)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_pending.pop_front();
                in_busy  <= 1'b1;
                if (burst_left <= 1)
                begin
                    pick       = $urandom_range(0, 9);
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= (pick < 4) ? 0 :
                                  (pick < 8) ? $urandom_range(1, 4) : $urandom_range(5, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern picked anew whenever the low six bits of the cycle counter are zero
    always @(negedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            case (ready_mode)
                RDY_ALWAYS:  out_ready <= 1'b1;
                RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
                RDY_QUARTER: out_ready <= (cycle_count[1:0] == 2'd0);
                default:
                begin
                    out_ready  <= ~out_ready;
                    ready_hold <= $urandom_range(0, 12);
                end
            endcase
        end
        if (cycle_count[5:0] == 6'd0)
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
    end

    // compare each output transaction, then predict from each input transaction
    always @(posedge clk)
    begin : watch
        body_byte_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (body_due.size() == 0)
                    flag_mismatch("output with no body byte due", frame_byte, 0);
                else
                begin
                    want = body_due.pop_front();
                    if (frame_byte !== want.data)
                        flag_mismatch("frame_byte", frame_byte, want.data);
                    if (is_first !== want.first)
                        flag_mismatch("is_first", is_first, want.first);
                    if (is_last !== want.last)
                        flag_mismatch("is_last", is_last, want.last);
                    if (sum_ok !== want.ok)
                        flag_mismatch("sum_ok", sum_ok, want.ok);
                    if (body_length !== want.length)
                        flag_mismatch("body_length", body_length, want.length);
                end
            end
            if (in_valid && in_ready)
            begin
                parse_byte(rx_byte);
                in_busy <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_SYNC_FIRST;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        out_ready   = 1'b0;
        in_busy     = 1'b0;
        burst_left  = 1;
        gap_left    = 0;
        ready_mode  = RDY_ALWAYS;
        ready_hold  = 0;
        cycle_count = 0;
        fail_count  = 0;
        parse_phase = PH_HUNT;
        cur_len     = '0;
        remaining   = '0;
        csum        = '0;
        sync_a      = SYNC_FIRST_RST;
        sync_b      = SYNC_SECOND_RST;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset pattern: noise, repeated first byte, zero length, broken hunt,
        // single-byte body, short good and bad frames
        rx_pending = '{8'h00, 8'hFF,
                       8'h4B, 8'h4B, 8'hB4, 8'h00,
                       8'h4B, 8'h17,
                       8'h4B, 8'hB4, 8'h01, 8'hFF};
        queue_frame(3, 1'b1);
        queue_frame(4, 1'b0);
        queue_random(30);
        // wait until everything has drained before queueing more
        wait_idle();
        queue_random(30);
        wait_idle();

        // extreme patterns
        write_sync(REG_SYNC_FIRST, 8'h00);
        write_sync(REG_SYNC_SECOND, 8'hFF);
        queue_random(30);
        wait_idle();

        write_sync(REG_SYNC_FIRST, 8'hFF);
        write_sync(REG_SYNC_SECOND, 8'h00);
        queue_random(30);
        wait_idle();

        // equal start bytes: a second match is taken as the second sync byte
        write_sync(REG_SYNC_FIRST, 8'h5A);
        write_sync(REG_SYNC_SECOND, 8'h5A);
        rx_pending = '{8'h5A, 8'h5A, 8'h02, 8'h11, 8'hED};
        queue_random(30);
        wait_idle();

        // random patterns
        repeat (2)
        begin
            write_sync(REG_SYNC_FIRST, 8'($urandom));
            write_sync(REG_SYNC_SECOND, 8'($urandom));
            queue_random(30);
            wait_idle();
        end

        // back to the reset pattern, with the longest body
        write_sync(REG_SYNC_FIRST, SYNC_FIRST_RST);
        write_sync(REG_SYNC_SECOND, SYNC_SECOND_RST);
        queue_frame(255, 1'b1);
        queue_random(30);

        while (rx_pending.size() != 0 || in_busy || body_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
